// ===== sv/sxh_pkg.sv =====
// Package for the substitution / key-XOR / hex codec.
// Holds the beat types, command codes, alphabet tables and lookup functions.
// No dependencies.
package sxh_pkg;

  localparam int KEY_LENGTH = 10;
  localparam int KEY_NIBBLES = 10;
  localparam int KEY_W = 4 * KEY_NIBBLES;
  localparam int POS_W = 4;
  localparam int ALPHA_SIZE = 71;
  localparam int CODE_W = 7;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [KEY_W-1:0] KEY_RESET = 40'h2115241218;
  localparam logic [7:0] END_MARK = 8'h3B;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [1:0] num;
    beat_t      b0;
    beat_t      b1;
  } push_t;

  localparam logic [CODE_W-1:0] CODE_OF [ALPHA_SIZE] = '{
    7'd67, 7'd58, 7'd44, 7'd39, 7'd21, 7'd16, 7'd5,  7'd63, 7'd56, 7'd41,
    7'd36, 7'd29, 7'd18, 7'd4,  7'd61, 7'd54, 7'd43, 7'd31, 7'd25, 7'd13,
    7'd7,  7'd66, 7'd51, 7'd42, 7'd40, 7'd22, 7'd11, 7'd1,  7'd70, 7'd52,
    7'd50, 7'd34, 7'd23, 7'd14, 7'd2,  7'd62, 7'd57, 7'd45, 7'd35, 7'd30,
    7'd12, 7'd3,  7'd64, 7'd55, 7'd48, 7'd32, 7'd28, 7'd17, 7'd9,  7'd68,
    7'd53, 7'd47, 7'd33, 7'd24, 7'd19, 7'd8,  7'd69, 7'd59, 7'd46, 7'd37,
    7'd27, 7'd15, 7'd6,  7'd65, 7'd60, 7'd49, 7'd38, 7'd26, 7'd20, 7'd10,
    7'd71
  };

  localparam logic [7:0] SYMBOL_OF [ALPHA_SIZE] = '{
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m",
    "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M",
    "N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "{", "}", "<", ">", ":", "[", "]", ",", 8'h22
  };

  // Code of a character, 0 when it is not in the alphabet.
  function automatic logic [CODE_W-1:0] code_of_char(input logic [7:0] ch);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (SYMBOL_OF[i] == ch) begin
        code = CODE_OF[i];
      end
    end
    return code;
  endfunction

  // Character of a code; hit low when no entry carries the code.
  function automatic logic [8:0] char_of_code(input logic [CODE_W-1:0] code);
    logic [8:0] res;
    res = '0;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (CODE_OF[i] == code) begin
        res = {1'b1, SYMBOL_OF[i]};
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

  // Nibble value with a valid flag in the top bit.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] res;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, ch[3:0]};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      res = {1'b1, ch[3:0] + 4'd9};
    end else begin
      res = 5'd0;
    end
    return res;
  endfunction

endpackage

// ===== sv/sxh_core.sv =====
// Codec core: key register, stream state and the encode / decode logic.
// Turns one registered input beat into up to two result beats.
// Depends on sxh_pkg.
module sxh_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [sxh_pkg::KEY_W-1:0] cfg_key,
  input  logic                      take,
  input  sxh_pkg::cmd_t             cmd,
  input  logic [7:0]                ch,
  output sxh_pkg::push_t            push
);

  logic [sxh_pkg::KEY_W-1:0] key_r;
  logic [sxh_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]                hi_r, hi_nxt;
  logic                      due_r, due_nxt;
  logic                      bad_r, bad_nxt;

  logic [sxh_pkg::POS_W-1:0] key_idx;
  logic [sxh_pkg::POS_W-1:0] pos_adv;
  logic [3:0]                kd;
  logic [sxh_pkg::CODE_W-1:0] enc_code;
  logic [7:0]                enc_v;
  logic [4:0]                hv;
  logic [sxh_pkg::CODE_W-1:0] dec_code;
  logic [8:0]                dec_hit;
  logic [7:0]                pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= sxh_pkg::KEY_RESET;
      pos_r <= '0;
      hi_r  <= '0;
      due_r <= 1'b0;
      bad_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_r <= cfg_key;
      end
      if (take) begin
        pos_r <= pos_nxt;
        hi_r  <= hi_nxt;
        due_r <= due_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

  always_comb begin
    key_idx = sxh_pkg::POS_W'(sxh_pkg::KEY_LENGTH - 1) - pos_r;
    if (pos_r >= sxh_pkg::POS_W'(sxh_pkg::KEY_LENGTH)) begin
      key_idx = sxh_pkg::POS_W'(sxh_pkg::KEY_LENGTH - 1);
    end
    kd = '0;
    for (int n = 0; n < sxh_pkg::KEY_NIBBLES; n++) begin
      if (key_idx == sxh_pkg::POS_W'(n)) begin
        kd = key_r[n*4 +: 4];
      end
    end
    if ({1'b0, pos_r} + 5'd1 >= 5'(sxh_pkg::KEY_LENGTH)) begin
      pos_adv = '0;
    end else begin
      pos_adv = pos_r + 4'd1;
    end
  end

  always_comb begin
    enc_code = sxh_pkg::code_of_char(ch);
    enc_v    = {enc_code ^ {3'd0, kd}, 1'b0};
    hv       = sxh_pkg::hex_value(ch);
    pair     = {hi_r, hv[3:0]};
    dec_code = pair[7:1] ^ {3'd0, kd};
    dec_hit  = sxh_pkg::char_of_code(dec_code);
  end

  always_comb begin
    pos_nxt  = pos_r;
    hi_nxt   = hi_r;
    due_nxt  = due_r;
    bad_nxt  = bad_r;
    push.num = 2'd0;
    push.b0  = '{char_out: sxh_pkg::hex_char(enc_v[7:4]), last: 1'b0};
    push.b1  = '{char_out: sxh_pkg::hex_char(enc_v[3:0]), last: 1'b0};
    case (cmd)
      sxh_pkg::CMD_ENCODE: begin
        if (enc_code != '0) begin
          push.num = 2'd2;
          pos_nxt  = pos_adv;
        end
      end
      sxh_pkg::CMD_FINISH: begin
        push.num = 2'd1;
        push.b0  = '{char_out: sxh_pkg::END_MARK, last: 1'b1};
        pos_nxt  = '0;
        hi_nxt   = '0;
        due_nxt  = 1'b0;
        bad_nxt  = 1'b0;
      end
      sxh_pkg::CMD_DECODE: begin
        if (ch == sxh_pkg::NUL_CHAR || ch == sxh_pkg::END_MARK) begin
          push.num = 2'd1;
          push.b0  = '{char_out: sxh_pkg::NUL_CHAR, last: 1'b1};
          pos_nxt  = '0;
          hi_nxt   = '0;
          due_nxt  = 1'b0;
          bad_nxt  = 1'b0;
        end else if (!due_r) begin
          bad_nxt = !hv[4];
          hi_nxt  = hv[3:0];
          due_nxt = 1'b1;
        end else begin
          pos_nxt = pos_adv;
          due_nxt = 1'b0;
          bad_nxt = 1'b0;
          push.b0 = '{char_out: dec_hit[7:0], last: 1'b0};
          if (!bad_r && hv[4] && dec_hit[8]) begin
            push.num = 2'd1;
          end
        end
      end
      default: begin
        push.num = 2'd0;
      end
    endcase
  end

endmodule

// ===== sv/sxh_outq.sv =====
// Result queue: four beat entries, up to two pushed and one popped per cycle.
// Depends on sxh_pkg.
module sxh_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_en,
  input  sxh_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output sxh_pkg::beat_t head
);

  sxh_pkg::beat_t mem_r [sxh_pkg::QDEPTH];
  logic [sxh_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [sxh_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                 npush;
  logic                       pop;

  always_comb begin
    npush     = push_en ? push.num : 2'd0;
    out_valid = cnt_r != '0;
    pop       = out_valid && out_ready;
    room      = cnt_r <= sxh_pkg::QCNT_W'(sxh_pkg::QDEPTH - 2);
    cnt_nxt   = cnt_r + {1'b0, npush} - {2'd0, pop};
    head      = mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      mem_r[wr_r] <= push.b0;
    end
    if (npush == 2'd2) begin
      mem_r[wr_r + 2'd1] <= push.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + npush;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/substitution_xor_hex_codec.sv =====
// Top level of the substitution / key-XOR / hex codec.
// Holds the input register and joins sxh_core and sxh_outq; uses sxh_pkg.
//
//   channel | direction | beat
//   in_     | in        | in_command, in_char_in
//   out_    | out       | out_char_out, out_last
//   cfg_    | in        | cfg_key_digits (always ready)
//
// An input beat waits in the input register until the queue has room; then the
// core writes its results into the four-entry queue. The next beat may follow
// every cycle while there is room. An encoded character yields two beats, so
// the result port sets the pace; a finish or a decoded character yields one.
// Input stalls when the queue holds more than two beats.
// Synchronous reset restores the key and clears the stream state and queue.
module substitution_xor_hex_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_out,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [39:0] cfg_key_digits
);

  logic           in_vld_r;
  sxh_pkg::cmd_t  in_cmd_r;
  logic [7:0]     in_char_r;
  logic           room;
  logic           take;
  sxh_pkg::push_t push;
  sxh_pkg::beat_t head;

  assign cfg_ready = 1'b1;
  assign take      = in_vld_r && room;
  assign in_ready  = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_cmd_r  <= sxh_pkg::cmd_t'(in_command);
      in_char_r <= in_char_in;
    end
  end

  sxh_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_key (cfg_key_digits),
    .take    (take),
    .cmd     (in_cmd_r),
    .ch      (in_char_r),
    .push    (push)
  );

  sxh_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (take),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_char_out = head.char_out;
  assign out_last     = head.last;

`ifndef ASSERT_OFF
  a_pair_only_on_encode: assert property (@(posedge clk) disable iff (!rst_n)
    take && push.num == 2'd2 |-> in_cmd_r == sxh_pkg::CMD_ENCODE)
    else $error("two beats from a non-encode command");

  a_end_beats: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_cmd_r == sxh_pkg::CMD_FINISH) |-> push.num == 2'd1 && push.b0.last)
    else $error("finish without a terminator beat");

  a_last_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char_out == sxh_pkg::END_MARK ||
                              out_char_out == sxh_pkg::NUL_CHAR)
    else $error("terminator beat with wrong byte");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && !room)
    else $error("input stalled without a held beat");
`endif

endmodule
